// ===== rtl/mrhsc_pkg.sv =====
`timescale 1ns / 1ps

package mrhsc_pkg;

	// Width of the counter input ports.
	localparam int FIELD_BITS = 48;

	// Rate arithmetic in parts per million.
	localparam int PPM_BITS = 20;
	localparam int QUOT_BITS = PPM_BITS + 1;
	localparam logic [PPM_BITS-1:0] PPM_SCALE = 20'd1000000;

	// Request kinds.
	localparam logic FUNC_SAMPLE = 1'b0;
	localparam logic FUNC_DECIDE = 1'b1;

	// Configuration register indexes.
	localparam int CFG_INDEX_BITS = 2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FORCE_SPILL = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_WATERMARK = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_MISS_HI = 2'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_MISS_LO = 2'd3;

	// Configuration reset values.
	localparam logic [15:0] WATERMARK_RESET = 16'd256;
	localparam logic [PPM_BITS-1:0] MISS_HI_RESET = 20'd50000;
	localparam logic [PPM_BITS-1:0] MISS_LO_RESET = 20'd20000;

	// Result of one rate computation. The value is the floor of the scaled
	// ratio, frac flags a nonzero remainder, and sat marks a ratio of two
	// or more.
	typedef struct packed {
		logic [QUOT_BITS-1:0] ppm;
		logic                 frac;
		logic                 sat;
	} ratio_res_t;

endpackage

// ===== rtl/mrhsc_sersub.sv =====
`timescale 1ns / 1ps

// Bit-serial subtractor. After load, each shift consumes the low bit of both
// operands and feeds the difference bit in at the top, so after W shifts the
// operand register holds a - b modulo 2^W.
module mrhsc_sersub #(
	parameter int W = 48
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load,
	input  logic         shift,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic [W-1:0] diff
);

	logic [W-1:0] a_q;
	logic [W-1:0] b_q;
	logic         borrow_q;
	logic         d_bit;
	logic         borrow_next;

	// One-bit full subtractor.
	assign d_bit = a_q[0] ^ b_q[0] ^ borrow_q;
	assign borrow_next = (~a_q[0] & (b_q[0] | borrow_q)) | (b_q[0] & borrow_q);

	// The borrow chain starts clear for every new operand pair.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			borrow_q <= 1'b0;
		end else if (load) begin
			borrow_q <= 1'b0;
		end else if (shift) begin
			borrow_q <= borrow_next;
		end
	end

	// Operand shift registers.
	always_ff @(posedge clk) begin
		if (load) begin
			a_q <= a;
			b_q <= b;
		end else if (shift) begin
			a_q <= {d_bit, a_q[W-1:1]};
			b_q <= {1'b0, b_q[W-1:1]};
		end
	end

	assign diff = a_q;

endmodule

// ===== rtl/mrhsc_ratio.sv =====
`timescale 1ns / 1ps

// Scaled ratio unit: floor(dm * 1e6 / dl) with remainder flag, one bit of
// the scale per step. Each doubling step and each step that adds the
// fractional numerator is one modular add against dl.
module mrhsc_ratio
	import mrhsc_pkg::*;
#(
	parameter int W = 48
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dm,
	input  logic [W-1:0] dl,
	output logic         done,
	output ratio_res_t   res
);

	localparam int IW = $clog2(PPM_BITS);

	typedef enum logic [2:0] {
		R_IDLE,
		R_CHK,
		R_WHOLE,
		R_DBL,
		R_ADD,
		R_FIN
	} rstate_t;

	rstate_t             state_q;
	logic [W-1:0]        dm_q;
	logic [W-1:0]        dl_q;
	logic [W-1:0]        num_q;
	logic [W-1:0]        r_q;
	logic [PPM_BITS-1:0] q_q;
	logic [IW-1:0]       i_q;
	logic                whole_q;
	logic                done_q;
	ratio_res_t          res_q;
	logic [W:0]          step;

	// Returns (r + x) mod d with the wrap flag on top; r and x are below d.
	function automatic logic [W:0] mod_add(input logic [W-1:0] r,
			input logic [W-1:0] x, input logic [W-1:0] d);
		logic [W:0] s;
		logic [W:0] t;
		logic       ge;
		s = {1'b0, r} + {1'b0, x};
		t = s - {1'b0, d};
		ge = (s >= {1'b0, d});
		return ge ? {1'b1, t[W-1:0]} : {1'b0, s[W-1:0]};
	endfunction

	// The doubling step adds the remainder to itself, the other step adds
	// the fractional numerator.
	always_comb begin
		step = mod_add(r_q, (state_q == R_ADD) ? num_q : r_q, dl_q);
	end

	// Sequencer with its working registers and registered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= R_IDLE;
			dm_q <= '0;
			dl_q <= '0;
			num_q <= '0;
			r_q <= '0;
			q_q <= '0;
			i_q <= '0;
			whole_q <= 1'b0;
			done_q <= 1'b0;
			res_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				R_IDLE: begin
					if (start) begin
						dm_q <= dm;
						dl_q <= dl;
						state_q <= R_CHK;
					end
				end
				R_CHK: begin
					if (dl_q == '0) begin
						// No loads: the rate is zero with no remainder.
						res_q <= '0;
						done_q <= 1'b1;
						state_q <= R_IDLE;
					end else if ({1'b0, dm_q} >= {dl_q, 1'b0}) begin
						// Ratio of two or more lies above every threshold.
						res_q.ppm <= '0;
						res_q.frac <= 1'b0;
						res_q.sat <= 1'b1;
						done_q <= 1'b1;
						state_q <= R_IDLE;
					end else begin
						whole_q <= (dm_q >= dl_q);
						state_q <= R_WHOLE;
					end
				end
				R_WHOLE: begin
					num_q <= whole_q ? (dm_q - dl_q) : dm_q;
					r_q <= '0;
					q_q <= '0;
					i_q <= IW'(PPM_BITS - 1);
					state_q <= R_DBL;
				end
				R_DBL: begin
					r_q <= step[W-1:0];
					q_q <= {q_q[PPM_BITS-2:0], step[W]};
					if (PPM_SCALE[i_q]) begin
						state_q <= R_ADD;
					end else if (i_q == '0) begin
						state_q <= R_FIN;
					end else begin
						i_q <= i_q - 1'b1;
					end
				end
				R_ADD: begin
					r_q <= step[W-1:0];
					q_q <= q_q + PPM_BITS'(step[W]);
					if (i_q == '0) begin
						state_q <= R_FIN;
					end else begin
						i_q <= i_q - 1'b1;
						state_q <= R_DBL;
					end
				end
				R_FIN: begin
					res_q.ppm <= whole_q ? ({1'b0, q_q} + {1'b0, PPM_SCALE}) : {1'b0, q_q};
					res_q.frac <= (r_q != '0);
					res_q.sat <= 1'b0;
					done_q <= 1'b1;
					state_q <= R_IDLE;
				end
				default: begin
					state_q <= R_IDLE;
				end
			endcase
		end
	end

	assign done = done_q;
	assign res = res_q;

endmodule

// ===== rtl/miss_rate_hysteresis_spill_control_unit.sv =====
`timescale 1ns / 1ps
// A decision request goes straight to the completion state, and a new request is taken
// only once the previous result has been written. A counter sample first runs the serial
// deltas, one counter bit per cycle, then the ratio unit (20 doubling steps, 7 add steps,
// plus its setup and finish steps) and a handoff to the completion state. A zero load
// delta or a ratio of two or more skips the doubling and add steps; output stalls hold the
// completion state. Reset is asynchronous, active low.

module miss_rate_hysteresis_spill_control_unit
	import mrhsc_pkg::*;
#(
	parameter int COUNTER_BITS = 48
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [PPM_BITS-1:0]       cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      func,
	input  logic [FIELD_BITS-1:0]     miss_count,
	input  logic [FIELD_BITS-1:0]     load_count,
	input  logic [15:0]               free_buffers,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      spill,
	output logic                      spill_active,
	output logic [PPM_BITS-1:0]       miss_ppm
);

	localparam int W = COUNTER_BITS;
	localparam int CW = $clog2(W);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DELTA,
		ST_RSTART,
		ST_RWAIT,
		ST_DONE
	} state_t;

	state_t              state_q;
	logic [CW-1:0]       cnt_q;
	logic                out_valid_q;
	logic                spill_q;
	logic                active_flag_q;
	logic [PPM_BITS-1:0] rate_ppm_q;
	logic                func_q;
	logic [15:0]         fb_q;
	logic [W-1:0]        prev_misses_q;
	logic [W-1:0]        prev_loads_q;

	logic                force_spill_q;
	logic [15:0]         spill_watermark_q;
	logic [PPM_BITS-1:0] miss_hi_ppm_q;
	logic [PPM_BITS-1:0] miss_lo_ppm_q;

	logic                in_accept;
	logic                sample_load;
	logic [W-1:0]        cm;
	logic [W-1:0]        cl;
	logic [W-1:0]        dm;
	logic [W-1:0]        dl;
	logic                ratio_done;
	ratio_res_t          ratio_res;
	logic                gt_hi;
	logic                lt_lo;
	logic                flag_next;
	logic [PPM_BITS-1:0] rate_next;
	logic                decide;
	logic                out_free;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			force_spill_q <= 1'b0;
			spill_watermark_q <= WATERMARK_RESET;
			miss_hi_ppm_q <= MISS_HI_RESET;
			miss_lo_ppm_q <= MISS_LO_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FORCE_SPILL: force_spill_q <= cfg_data[0];
				REG_WATERMARK:   spill_watermark_q <= cfg_data[15:0];
				REG_MISS_HI:     miss_hi_ppm_q <= cfg_data;
				REG_MISS_LO:     miss_lo_ppm_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Request handshake and counter inputs trimmed to the counter width.
	assign in_stall = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign sample_load = in_accept && (func == FUNC_SAMPLE);
	assign cm = W'(miss_count);
	assign cl = W'(load_count);

	// Serial deltas against the previous sample.
	mrhsc_sersub #(.W(W)) u_miss_delta (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (sample_load),
		.shift  (state_q == ST_DELTA),
		.a      (cm),
		.b      (prev_misses_q),
		.diff   (dm)
	);

	mrhsc_sersub #(.W(W)) u_load_delta (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (sample_load),
		.shift  (state_q == ST_DELTA),
		.a      (cl),
		.b      (prev_loads_q),
		.diff   (dl)
	);

	// Scaled miss ratio.
	mrhsc_ratio #(.W(W)) u_ratio (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_RSTART),
		.dm     (dm),
		.dl     (dl),
		.done   (ratio_done),
		.res    (ratio_res)
	);

	// Hysteresis decision on the exact rate and the saturated report value.
	always_comb begin
		gt_hi = ratio_res.sat || (ratio_res.ppm > {1'b0, miss_hi_ppm_q}) ||
			((ratio_res.ppm == {1'b0, miss_hi_ppm_q}) && ratio_res.frac);
		lt_lo = !ratio_res.sat && (ratio_res.ppm < {1'b0, miss_lo_ppm_q});
		flag_next = active_flag_q ? !lt_lo : gt_hi;
		if (ratio_res.sat || (ratio_res.ppm > {1'b0, PPM_SCALE})) begin
			rate_next = PPM_SCALE;
		end else begin
			rate_next = ratio_res.ppm[PPM_BITS-1:0];
		end
		decide = force_spill_q || active_flag_q || (fb_q < spill_watermark_q);
	end

	assign out_free = !out_valid_q || !out_stall;

	// Sequencer, rate state and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
			spill_q <= 1'b0;
			active_flag_q <= 1'b0;
			rate_ppm_q <= '0;
			func_q <= FUNC_SAMPLE;
			fb_q <= '0;
			prev_misses_q <= '0;
			prev_loads_q <= '0;
		end else begin
			// A taken result clears unless the completion state loads the next one.
			if (out_valid_q && !out_stall && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						func_q <= func;
						fb_q <= free_buffers;
						if (func == FUNC_SAMPLE) begin
							prev_misses_q <= cm;
							prev_loads_q <= cl;
							cnt_q <= CW'(W - 1);
							state_q <= ST_DELTA;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DELTA: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_RSTART;
					end
				end
				ST_RSTART: begin
					state_q <= ST_RWAIT;
				end
				ST_RWAIT: begin
					if (ratio_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// Wait until the result register is free.
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (func_q == FUNC_DECIDE) begin
							spill_q <= decide;
						end else begin
							spill_q <= 1'b0;
							active_flag_q <= flag_next;
							rate_ppm_q <= rate_next;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The flag and rate change only when a result is written, so they serve
	// directly as the result fields.
	assign out_valid = out_valid_q;
	assign spill = spill_q;
	assign spill_active = active_flag_q;
	assign miss_ppm = rate_ppm_q;

	// The ratio unit finishes only while the sequencer waits for it.
	a_ratio_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		ratio_done |-> (state_q == ST_RWAIT))
		else $error("ratio unit finished outside the wait state");

	// A reported rate never exceeds the full scale.
	a_rate_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (miss_ppm <= PPM_SCALE))
		else $error("miss rate above full scale");

	// The hysteresis flag moves only when a sample completes.
	a_flag_on_sample: assert property (@(posedge clk) disable iff (!arst_n)
		(spill_active != $past(spill_active)) |->
			($past(state_q == ST_DONE) && $past(func_q == FUNC_SAMPLE)))
		else $error("spill flag changed outside a sample completion");

	// A new result appears only out of the completion state.
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_DONE))
		else $error("result raised outside the completion state");

endmodule
